FILE: src/cdts_pkg.sv
// ----------------------------------------------------------------------------
// cdts_pkg
// shared types, constants and calendar tables for the date-to-seconds pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdts_pkg;

    localparam int YearW    = 14;
    localparam int MonthW   = 4;
    localparam int DayW     = 5;
    localparam int HourW    = 5;
    localparam int MinuteW  = 6;
    localparam int SecondW  = 6;
    localparam int DaysW    = 22;
    localparam int TodW     = 17;
    localparam int ElapsedW = 39;
    localparam int ProdW    = 27;
    localparam int QuotW    = 8;
    localparam int RemW     = 7;
    localparam int MdayW    = 9;

    localparam logic [YearW-1:0]   YearMax      = 14'd9999;
    localparam logic [MonthW-1:0]  MonthMax     = 4'd12;
    localparam logic [MonthW-1:0]  MonthFeb     = 4'd2;
    localparam logic [HourW-1:0]   HourMax      = 5'd23;
    localparam logic [MinuteW-1:0] MinuteMax    = 6'd59;
    localparam logic [SecondW-1:0] SecondMax    = 6'd59;
    localparam logic [ProdW-1:0]   Recip100     = 27'd5243;
    localparam int                 Recip100Sh   = 19;
    localparam logic [YearW-1:0]   Hundred      = 14'd100;
    localparam logic [RemW-1:0]    RemCentury   = 7'd99;
    localparam logic [DaysW-1:0]   DaysPerYear  = 22'd365;
    localparam logic [TodW-1:0]    SecsPerHour  = 17'd3600;
    localparam logic [TodW-1:0]    SecsPerMin   = 17'd60;
    localparam logic [ElapsedW-1:0] SecsPerDay  = 39'd86400;
    localparam logic [ElapsedW-1:0] ElapsedMax  = 39'd315537897599;

    typedef struct packed {
        logic [SecondW-1:0] second;
        logic [MinuteW-1:0] minute;
        logic [HourW-1:0]   hour;
        logic [DayW-1:0]    day;
        logic [MonthW-1:0]  month;
        logic [YearW-1:0]   year;
    } cdts_in_t;

    typedef struct packed {
        logic             ok;
        logic [DaysW-1:0] days;
        logic [TodW-1:0]  tod;
    } cdts_day_item_t;

    typedef struct packed {
        logic                valid_res;
        logic [ElapsedW-1:0] elapsed_seconds;
    } cdts_out_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mo);
        logic [DayW-1:0] len;
        unique case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [MdayW-1:0] days_before_month(input logic [MonthW-1:0] mo);
        logic [MdayW-1:0] dbm;
        unique case (mo)
            4'd2:    dbm = 9'd31;
            4'd3:    dbm = 9'd59;
            4'd4:    dbm = 9'd90;
            4'd5:    dbm = 9'd120;
            4'd6:    dbm = 9'd151;
            4'd7:    dbm = 9'd181;
            4'd8:    dbm = 9'd212;
            4'd9:    dbm = 9'd243;
            4'd10:   dbm = 9'd273;
            4'd11:   dbm = 9'd304;
            4'd12:   dbm = 9'd334;
            default: dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

FILE: src/civil_date_to_seconds_top.sv
// ----------------------------------------------------------------------------
// civil_date_to_seconds_top
// gregorian date and time to seconds since 0001-01-01T00:00:00
//
//   channel   dir   handshake          payload
//   s_        in    s_tvalid/s_tready  s_tdata: year, month, day, hour, minute, second
//   m_        out   m_tvalid/m_tready  m_tuser: valid_res; m_tdata: elapsed_seconds
//
// five register stages, one item per cycle sustained while m_tready stays high
// each stage holds its item when the next one is full and cannot move, bubbles are squeezed out
// a stall on m_ loses and repeats nothing; s_tready falls only when all stages hold
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module civil_date_to_seconds_top import cdts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // year, month, day, hour, minute, second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // elapsed_seconds, zero pad
    output logic [0:0]  m_tuser    // valid_res
);

    cdts_in_t       in_item;
    cdts_day_item_t day_item;
    cdts_out_t      out_item;
    logic           day_valid;
    logic           day_ready;

    assign in_item = s_tdata;

    cdts_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .out_item  (day_item)
    );

    cdts_secs u_secs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (day_valid),
        .in_ready  (day_ready),
        .in_item   (day_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {1'b0, out_item.elapsed_seconds};
    assign m_tuser = out_item.valid_res;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid item with nonzero count");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[ElapsedW-1:0] <= ElapsedMax)
        else $error("elapsed seconds beyond last representable date");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while pipeline can move");

endmodule

FILE: src/cdts_days.sv
// ----------------------------------------------------------------------------
// cdts_days
// three-stage calendar front end: range checks, leap year, day count, time of day
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdts_days import cdts_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cdts_in_t       in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output cdts_day_item_t out_item
);

    // stage 1
    logic               v1_reg;
    logic               ok1_reg;
    logic [YearW-1:0]   py1_reg;
    logic [ProdW-1:0]   prod1_reg;
    logic [MonthW-1:0]  mo1_reg;
    logic [DayW-1:0]    d1_reg;
    logic [HourW-1:0]   h1_reg;
    logic [MinuteW-1:0] mi1_reg;
    logic [SecondW-1:0] s1_reg;
    logic               ok1_next;
    logic [YearW-1:0]   py1_next;

    // stage 2
    logic               v2_reg;
    logic               ok2_reg;
    logic [DaysW-1:0]   yday2_reg;
    logic [MdayW-1:0]   mday2_reg;
    logic [TodW-1:0]    tod2_reg;
    logic [QuotW-1:0]   q100;
    logic [RemW-1:0]    rem100;
    logic               leap;
    logic [DayW:0]      limit;
    logic               ok2_next;
    logic [DaysW-1:0]   yday2_next;
    logic [MdayW-1:0]   mday2_next;
    logic [TodW-1:0]    tod2_next;

    // stage 3
    logic               v3_reg;
    cdts_day_item_t     item3_reg;

    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        ok1_next = (in_item.year != '0) && (in_item.year <= YearMax) &&
                   (in_item.month != '0) && (in_item.month <= MonthMax) &&
                   (in_item.day != '0) && (in_item.hour <= HourMax) &&
                   (in_item.minute <= MinuteMax) && (in_item.second <= SecondMax);
        py1_next = in_item.year - YearW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= in_valid;
        end
        if (rdy1 && in_valid) begin
            ok1_reg   <= ok1_next;
            py1_reg   <= py1_next;
            prod1_reg <= ProdW'(py1_next) * Recip100;
            mo1_reg   <= in_item.month;
            d1_reg    <= in_item.day;
            h1_reg    <= in_item.hour;
            mi1_reg   <= in_item.minute;
            s1_reg    <= in_item.second;
        end
    end

    // py / 100 from the reciprocal product, py / 400 = (py / 100) / 4
    always_comb begin
        q100   = prod1_reg[Recip100Sh +: QuotW];
        rem100 = RemW'(py1_reg - YearW'(Hundred * YearW'(q100)));
        leap   = ((rem100 == RemCentury) && (q100[1:0] == 2'b11)) ||
                 ((py1_reg[1:0] == 2'b11) && (rem100 != RemCentury));
        limit  = {1'b0, month_len(mo1_reg)} +
                 (DayW+1)'((mo1_reg == MonthFeb) && leap);
        ok2_next   = ok1_reg && ({1'b0, d1_reg} <= limit);
        yday2_next = DaysPerYear * DaysW'(py1_reg) + DaysW'(py1_reg[YearW-1:2]) -
                     DaysW'(q100) + DaysW'(q100[QuotW-1:2]);
        mday2_next = days_before_month(mo1_reg) +
                     MdayW'((mo1_reg > MonthFeb) && leap) +
                     MdayW'(d1_reg) - MdayW'(1);
        tod2_next  = SecsPerHour * TodW'(h1_reg) + SecsPerMin * TodW'(mi1_reg) +
                     TodW'(s1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            ok2_reg   <= ok2_next;
            yday2_reg <= yday2_next;
            mday2_reg <= mday2_next;
            tod2_reg  <= tod2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3 && v2_reg) begin
            item3_reg.ok   <= ok2_reg;
            item3_reg.days <= yday2_reg + DaysW'(mday2_reg);
            item3_reg.tod  <= tod2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

FILE: src/cdts_secs.sv
// ----------------------------------------------------------------------------
// cdts_secs
// two-stage back end: days times seconds per day, then time of day and zeroing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdts_secs import cdts_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cdts_day_item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output cdts_out_t      out_item
);

    logic                v4_reg;
    logic                ok4_reg;
    logic [ElapsedW-1:0] prod4_reg;
    logic [TodW-1:0]     tod4_reg;
    logic                v5_reg;
    cdts_out_t           out5_reg;
    logic                rdy4, rdy5;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= in_valid;
        end
        if (rdy4 && in_valid) begin
            ok4_reg   <= in_item.ok;
            prod4_reg <= ElapsedW'(in_item.days) * SecsPerDay;
            tod4_reg  <= in_item.tod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (rdy5) begin
            v5_reg <= v4_reg;
        end
        if (rdy5 && v4_reg) begin
            out5_reg.valid_res       <= ok4_reg;
            out5_reg.elapsed_seconds <= ok4_reg ? prod4_reg + ElapsedW'(tod4_reg) : '0;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = out5_reg;

endmodule

FILE: sim/civil_date_to_seconds_top_tb.sv
// ----------------------------------------------------------------------------
// civil_date_to_seconds_top_tb
// self-checking bench for the gregorian date to elapsed seconds pipeline
//
// a queue of date items feeds a clocked driver on s_, a clocked monitor on m_
// compares every result with a local calendar predictor, field by field.
// directed corner dates come first, then random dates that are mostly legal,
// some with one field pushed out of range, some plain noise. both sides idle
// in random bursts except near the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module civil_date_to_seconds_top_tb;
    import cdts_pkg::*;

    localparam int RandomItems = 850;
    localparam int CalmTail    = 120;
    localparam int DrainCycles = 12;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    cdts_in_t  pending_dates[$];
    cdts_out_t expected_stamps[$];
    cdts_out_t want_stamp;
    int        mismatches = 0;
    int        gap_left   = 0;
    int        stall_left = 0;

    civil_date_to_seconds_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mo, input bit leap);
        case (mo)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned days_ahead(input int unsigned mo);
        int unsigned acc;
        acc = 0;
        for (int unsigned m = 1; m < mo; m++) begin
            acc += days_in_month(m, 1'b0);
        end
        return acc;
    endfunction

    function automatic cdts_out_t civil_to_stamp(input cdts_in_t d);
        cdts_out_t       r;
        int unsigned     y, mo, dd, hh, mi, ss;
        bit              leap;
        longint unsigned py, days;
        r  = '0;
        y  = 32'(d.year);
        mo = 32'(d.month);
        dd = 32'(d.day);
        hh = 32'(d.hour);
        mi = 32'(d.minute);
        ss = 32'(d.second);
        if (y < 1 || y > 9999 || mo < 1 || mo > 12 || dd < 1 ||
            hh > 23 || mi > 59 || ss > 59) begin
            return r;
        end
        leap = is_leap(y);
        if (dd > days_in_month(mo, leap)) begin
            return r;
        end
        py   = 64'(y - 1);
        days = 365 * py + py / 4 - py / 100 + py / 400 + 64'(days_ahead(mo)) +
               64'(dd) - 1;
        if (mo > 2 && leap) begin
            days += 1;
        end
        r.valid_res       = 1'b1;
        r.elapsed_seconds = ElapsedW'(days * 86400 + 64'(hh) * 3600 + 64'(mi) * 60 +
                                      64'(ss));
        return r;
    endfunction

    function automatic cdts_in_t make_date(input int unsigned y, mo, d, h, mi, s);
        cdts_in_t r;
        r.year   = YearW'(y);
        r.month  = MonthW'(mo);
        r.day    = DayW'(d);
        r.hour   = HourW'(h);
        r.minute = MinuteW'(mi);
        r.second = SecondW'(s);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_stamps.push_back(civil_to_stamp(cdts_in_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_dates.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_dates.size() > CalmTail && $urandom_range(0, 7) == 0) begin
                    gap_left <= int'($urandom_range(1, 18) - 1);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= pending_dates.pop_front();
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_stamps.size() == 0) begin
                    report_mismatch($sformatf("unexpected item tuser=%b tdata=%h",
                                              m_tuser, m_tdata));
                end else begin
                    want_stamp = expected_stamps.pop_front();
                    if (m_tuser[0] !== want_stamp.valid_res) begin
                        report_mismatch($sformatf("valid_res %b, want %b",
                                                  m_tuser[0], want_stamp.valid_res));
                    end
                    if (m_tdata[38:0] !== want_stamp.elapsed_seconds) begin
                        report_mismatch($sformatf("elapsed_seconds %0d, want %0d",
                                                  m_tdata[38:0], want_stamp.elapsed_seconds));
                    end
                    if (m_tdata[39] !== 1'b0) begin
                        report_mismatch("tdata pad bit not zero");
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (pending_dates.size() > CalmTail && $urandom_range(0, 7) == 0) begin
                stall_left <= int'($urandom_range(1, 18) - 1);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cdts_in_t    item;
        int unsigned kind, len;

        // corner dates
        pending_dates.push_back(make_date(1, 1, 1, 0, 0, 0));
        pending_dates.push_back(make_date(9999, 12, 31, 23, 59, 59));
        pending_dates.push_back(make_date(0, 6, 15, 12, 30, 30));
        pending_dates.push_back(make_date(10000, 1, 1, 0, 0, 0));
        pending_dates.push_back(make_date(16383, 15, 31, 31, 63, 63));
        pending_dates.push_back(make_date(2001, 0, 10, 1, 1, 1));
        pending_dates.push_back(make_date(2001, 13, 10, 1, 1, 1));
        pending_dates.push_back(make_date(2001, 15, 10, 1, 1, 1));
        pending_dates.push_back(make_date(2001, 3, 0, 1, 1, 1));
        pending_dates.push_back(make_date(2001, 4, 31, 1, 1, 1));
        pending_dates.push_back(make_date(2024, 2, 29, 8, 0, 0));
        pending_dates.push_back(make_date(2023, 2, 29, 8, 0, 0));
        pending_dates.push_back(make_date(1900, 2, 29, 8, 0, 0));
        pending_dates.push_back(make_date(2000, 2, 29, 8, 0, 0));
        pending_dates.push_back(make_date(2000, 12, 31, 23, 59, 59));
        pending_dates.push_back(make_date(2000, 3, 1, 0, 0, 0));
        pending_dates.push_back(make_date(1900, 3, 1, 0, 0, 0));
        pending_dates.push_back(make_date(2010, 7, 4, 24, 0, 0));
        pending_dates.push_back(make_date(2010, 7, 4, 31, 0, 0));
        pending_dates.push_back(make_date(2010, 7, 4, 0, 60, 0));
        pending_dates.push_back(make_date(2010, 7, 4, 0, 63, 0));
        pending_dates.push_back(make_date(2010, 7, 4, 0, 0, 60));
        pending_dates.push_back(make_date(2010, 7, 4, 0, 0, 63));
        pending_dates.push_back(make_date(1, 1, 31, 23, 59, 59));

        for (int i = 0; i < RandomItems; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                item = cdts_in_t'(40'({$urandom, $urandom}));
            end else begin
                case ($urandom_range(0, 3))
                    0:       item.year = YearW'($urandom_range(1, 9999));
                    1:       item.year = YearW'($urandom_range(1, 50));
                    2:       item.year = YearW'($urandom_range(9950, 9999));
                    default: item.year = YearW'($urandom_range(1, 99) * 100);
                endcase
                item.month = MonthW'($urandom_range(1, 12));
                len = days_in_month(32'(item.month), is_leap(32'(item.year)));
                item.day    = DayW'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
                item.hour   = HourW'($urandom_range(0, 23));
                item.minute = MinuteW'($urandom_range(0, 59));
                item.second = SecondW'($urandom_range(0, 59));
                // push one field out of range
                if (kind < 35) begin
                    case ($urandom_range(0, 6))
                        0: item.year  = YearW'($urandom_range(0, 1) ? 0 :
                                               $urandom_range(10000, 16383));
                        1: item.month = MonthW'($urandom_range(0, 1) ? 0 :
                                                $urandom_range(13, 15));
                        2: item.day   = '0;
                        3: item.day   = DayW'((len < 31) ? $urandom_range(len + 1, 31) : 0);
                        4: item.hour   = HourW'($urandom_range(24, 31));
                        5: item.minute = MinuteW'($urandom_range(60, 63));
                        default: item.second = SecondW'($urandom_range(60, 63));
                    endcase
                end
            end
            pending_dates.push_back(item);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_dates.size() != 0 || s_tvalid || expected_stamps.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);

        if (mismatches == 0) begin
            $display("civil_date_to_seconds_top_tb: PASS");
        end else begin
            $display("civil_date_to_seconds_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("civil_date_to_seconds_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/cdts_pkg.sv
src/cdts_days.sv
src/cdts_secs.sv
src/civil_date_to_seconds_top.sv
sim/civil_date_to_seconds_top_tb.sv
